// ===== sv/md5xf_pkg.sv =====
// Shared types, constants and round functions of the folded MD5 digest block.
`default_nettype none
package md5xf_pkg;

	localparam int unsigned CountW = 61;
	localparam int unsigned WordW  = 32;
	localparam int unsigned Words  = 16;
	localparam int unsigned RoundW = 6;

	// Chaining value after reset
	localparam logic [WordW-1:0] IV [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};

	// Round additive constants
	localparam logic [WordW-1:0] SINE [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// Rotate amounts, indexed by group and step within four
	localparam logic [4:0] ROT [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	// Commands from the controller to the datapath
	typedef struct packed {
		logic wr_byte;
		logic load;
		logic round;
		logic add_cv;
		logic pad;
		logic len;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic blk_full;
		logic pad_over;
		logic last_round;
		logic out_free;
	} sts_t;

	// Message word index used by a round
	function automatic logic [3:0] msg_idx(input logic [RoundW-1:0] k);
		logic [3:0] r;
		r = 4'(k[3:0]);
		unique case (k[5:4])
			2'd0: msg_idx = r;
			2'd1: msg_idx = 4'(r * 4'd5 + 4'd1);
			2'd2: msg_idx = 4'(r * 4'd3 + 4'd5);
			default: msg_idx = 4'(r * 4'd7);
		endcase
	endfunction

	// Nonlinear mixing function of a round group
	function automatic logic [WordW-1:0] mix(input logic [1:0] grp,
			input logic [WordW-1:0] b, input logic [WordW-1:0] c,
			input logic [WordW-1:0] d);
		unique case (grp)
			2'd0: mix = (b & c) | (~b & d);
			2'd1: mix = (b & d) | (c & ~d);
			2'd2: mix = b ^ c ^ d;
			default: mix = c ^ (b | ~d);
		endcase
	endfunction

	function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x,
			input logic [4:0] s);
		logic [2*WordW-1:0] dbl;
		dbl = {x, x} << s;
		rotl = dbl[2*WordW-1:WordW];
	endfunction

endpackage
`default_nettype wire

// ===== sv/md5xf_dp.sv =====
// Datapath: block buffer, byte count, round registers, chaining value and result register.
`default_nettype none
module md5xf_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire md5xf_pkg::cmd_t    cmd,
	input  wire logic [7:0]         s_data,
	input  wire logic               m_tready,
	output md5xf_pkg::sts_t         sts,
	output logic                    m_tvalid,
	output logic [63:0]             m_tdata
);

	logic [md5xf_pkg::WordW-1:0]  blk_q [md5xf_pkg::Words];
	logic [md5xf_pkg::CountW-1:0] count_q;
	logic [md5xf_pkg::WordW-1:0]  cv_q [4];
	logic [md5xf_pkg::WordW-1:0]  a_q, b_q, c_q, d_q, pre_q;
	logic [md5xf_pkg::RoundW-1:0] k_q;
	logic                         out_valid_q;
	logic [63:0]                  out_data_q;

	logic [5:0]                   pos;
	logic [63:0]                  len_bits;
	logic [md5xf_pkg::WordW-1:0]  pad_word;
	logic [md5xf_pkg::RoundW-1:0] k_next;
	logic [md5xf_pkg::WordW-1:0]  t_sum, new_b, pre_next, w0, w1;

	assign pos      = count_q[5:0];
	assign len_bits = {count_q, 3'b000};
	assign k_next   = k_q + 6'd1;

	// Merge 0x80 into the word holding the pad position, clear the lanes above it
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			if (2'(j) < pos[1:0]) begin
				pad_word[8*j +: 8] = blk_q[pos[5:2]][8*j +: 8];
			end else if (2'(j) == pos[1:0]) begin
				pad_word[8*j +: 8] = 8'h80;
			end else begin
				pad_word[8*j +: 8] = 8'h00;
			end
		end
	end

	// One round step; the next round's a + K + M is prepared alongside
	assign t_sum    = pre_q + md5xf_pkg::mix(k_q[5:4], b_q, c_q, d_q);
	assign new_b    = b_q + md5xf_pkg::rotl(t_sum, md5xf_pkg::ROT[{k_q[5:4], k_q[1:0]}]);
	assign pre_next = d_q + md5xf_pkg::SINE[k_next] + blk_q[md5xf_pkg::msg_idx(k_next)];

	// Fold the digest: byte 0 of word 0 lands in the top byte
	assign w0 = cv_q[0] ^ cv_q[2];
	assign w1 = cv_q[1] ^ cv_q[3];

	// Block buffer writes: message bytes, padding, length
	always_ff @(posedge clk) begin
		if (cmd.wr_byte) begin
			blk_q[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= s_data;
		end else if (cmd.pad) begin
			for (int i = 0; i < md5xf_pkg::Words; i++) begin
				if (4'(i) == pos[5:2]) begin
					blk_q[i] <= pad_word;
				end else if (4'(i) > pos[5:2]) begin
					blk_q[i] <= '0;
				end
			end
			if (!sts.pad_over) begin
				blk_q[14] <= len_bits[31:0];
				blk_q[15] <= len_bits[63:32];
			end
		end else if (cmd.len) begin
			for (int i = 0; i < 14; i++) begin
				blk_q[i] <= '0;
			end
			blk_q[14] <= len_bits[31:0];
			blk_q[15] <= len_bits[63:32];
		end
	end

	// Round registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q   <= cv_q[0];
			b_q   <= cv_q[1];
			c_q   <= cv_q[2];
			d_q   <= cv_q[3];
			pre_q <= cv_q[0] + md5xf_pkg::SINE[0] + blk_q[0];
		end else if (cmd.round) begin
			a_q   <= d_q;
			b_q   <= new_b;
			c_q   <= b_q;
			d_q   <= c_q;
			pre_q <= pre_next;
		end
	end

	// Round counter, byte count and chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			count_q <= '0;
			for (int i = 0; i < 4; i++) begin
				cv_q[i] <= md5xf_pkg::IV[i];
			end
		end else begin
			if (cmd.load) begin
				k_q <= '0;
			end else if (cmd.round) begin
				k_q <= k_next;
			end
			if (cmd.wr_byte) begin
				count_q <= count_q + 61'd1;
			end else if (cmd.emit) begin
				count_q <= '0;
			end
			if (cmd.add_cv) begin
				cv_q[0] <= cv_q[0] + a_q;
				cv_q[1] <= cv_q[1] + b_q;
				cv_q[2] <= cv_q[2] + c_q;
				cv_q[3] <= cv_q[3] + d_q;
			end else if (cmd.emit) begin
				for (int i = 0; i < 4; i++) begin
					cv_q[i] <= md5xf_pkg::IV[i];
				end
			end
		end
	end

	// Result register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= {w0[7:0], w0[15:8], w0[23:16], w0[31:24],
				w1[7:0], w1[15:8], w1[23:16], w1[31:24]};
		end
	end

	assign m_tvalid       = out_valid_q;
	assign m_tdata        = out_data_q;
	assign sts.blk_full   = (pos == 6'd63);
	assign sts.pad_over   = (pos[5:3] == 3'b111);
	assign sts.last_round = (k_q == 6'd63);
	assign sts.out_free   = !out_valid_q || m_tready;

endmodule
`default_nettype wire

// ===== sv/md5xf_ctrl.sv =====
// Controller: sequences byte intake, compression, padding and result hand-off.
`default_nettype none
module md5xf_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	input  wire logic               s_tlast,
	input  wire md5xf_pkg::sts_t    sts,
	output logic                    s_tready,
	output md5xf_pkg::cmd_t         cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_ADD   = 3'd3;
	localparam logic [2:0] ST_PAD   = 3'd4;
	localparam logic [2:0] ST_LEN   = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	localparam logic [1:0] MODE_DATA = 2'd0;
	localparam logic [1:0] MODE_PAD  = 2'd1;
	localparam logic [1:0] MODE_LEN  = 2'd2;

	logic [2:0] state_q, state_d;
	logic [1:0] mode_q, mode_d;
	logic       last_q, last_d;
	logic       take;

	assign s_tready = (state_q == ST_IDLE);
	assign take     = s_tvalid && s_tready;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		last_d  = last_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					cmd.wr_byte = 1'b1;
					last_d      = s_tlast;
					if (sts.blk_full) begin
						mode_d  = MODE_DATA;
						state_d = ST_LOAD;
					end else if (s_tlast) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (sts.last_round) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.add_cv = 1'b1;
				unique case (mode_q)
					MODE_DATA: state_d = last_q ? ST_PAD : ST_IDLE;
					MODE_PAD:  state_d = sts.pad_over ? ST_LEN : ST_EMIT;
					default:   state_d = ST_EMIT;
				endcase
			end
			ST_PAD: begin
				cmd.pad = 1'b1;
				mode_d  = MODE_PAD;
				state_d = ST_LOAD;
			end
			ST_LEN: begin
				cmd.len = 1'b1;
				mode_d  = MODE_LEN;
				state_d = ST_LOAD;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					last_d   = 1'b0;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_DATA;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			last_q  <= last_d;
		end
	end

endmodule
`default_nettype wire

// ===== sv/md5_xor_folded_digest_top.sv =====
// Top level: MD5 over a byte stream, digest folded to 64 bits by XOR.
// Bytes transfer one per cycle while intake is open; a full 64-byte block stalls intake for
// the load, 64 rounds and chaining add. After the last byte: the same again if it completed
// a block, then a pad step and a compression, a length step and another compression if the
// length spills into a second block, then the result register is loaded, held while an
// earlier result waits. Async reset restores IV, count, drops any result.
`default_nettype none
module md5_xor_folded_digest_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,   // last_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata    // [63:0] folded_hash
);

	md5xf_pkg::cmd_t cmd;
	md5xf_pkg::sts_t sts;

	md5xf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.sts      (sts),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	md5xf_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.s_data   (s_tdata),
		.m_tready (m_tready),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

	// At most one datapath command per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_byte, cmd.load, cmd.round, cmd.add_cv, cmd.pad, cmd.len, cmd.emit}))
		else $error("more than one datapath command");

	// No byte intake while a block is being processed
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.round || cmd.load || cmd.pad || cmd.len || cmd.add_cv) |-> !s_tready)
		else $error("intake open during compression");

	// A result is loaded only when the output register is free
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result overwritten before transfer");

	// Loading a result raises valid next cycle
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_tvalid)
		else $error("result not presented after emit");

endmodule
`default_nettype wire

// ===== dv/tb_md5_xor_folded_digest_top.sv =====
// Self-checking bench: byte messages streamed in, folded MD5 digests scored against a predictor.
module tb_md5_xor_folded_digest_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LIMIT_CYCLES = 2000000;
	localparam int unsigned RANDOM_BYTES = 1300;
	localparam int unsigned LONG_HOLD    = 600;
	localparam int unsigned SETTLE       = 300;
	localparam int          DIR_N        = 20;

	// Per-step rotate amounts, four per round group
	localparam int ROT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;

	md5_xor_folded_digest_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// One directed byte; the digest is typed in only for well-known short strings
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        known;
		logic [63:0] hash;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		// "a"
		{8'h61, 1'b1, 1'b1, 64'h3d02ec5ba98690c9},
		// "abc"
		{8'h61, 1'b0, 1'b0, 64'h0},
		{8'h62, 1'b0, 1'b0, 64'h0},
		{8'h63, 1'b1, 1'b1, 64'h46976fe5143330c2},
		// single-byte extremes, and a byte equal to the pad marker
		{8'h00, 1'b1, 1'b0, 64'h0},
		{8'hff, 1'b1, 1'b0, 64'h0},
		{8'h80, 1'b1, 1'b0, 64'h0},
		// alternating patterns
		{8'h00, 1'b0, 1'b0, 64'h0},
		{8'hff, 1'b0, 1'b0, 64'h0},
		{8'h00, 1'b0, 1'b0, 64'h0},
		{8'hff, 1'b0, 1'b0, 64'h0},
		{8'h55, 1'b0, 1'b0, 64'h0},
		{8'haa, 1'b1, 1'b0, 64'h0},
		// walking one
		{8'h01, 1'b0, 1'b0, 64'h0},
		{8'h02, 1'b0, 1'b0, 64'h0},
		{8'h04, 1'b0, 1'b0, 64'h0},
		{8'h08, 1'b0, 1'b0, 64'h0},
		{8'h10, 1'b0, 1'b0, 64'h0},
		{8'h20, 1'b0, 1'b0, 64'h0},
		{8'h40, 1'b1, 1'b0, 64'h0}
	};

	// Predictor state: chaining words, current block, running byte count
	logic [31:0] chain [4];
	logic [7:0]  block_bytes [64];
	logic [60:0] byte_total;
	logic [31:0] sine_k [64];

	// Folded digests waiting for the output side
	logic [63:0] digest_q [$];

	int errors        = 0;
	int results_seen  = 0;
	int bytes_sent    = 0;
	int msgs_sent     = 0;
	int cycles        = 0;
	int tx_idle_pct   = 0;
	int rx_idle_pct   = 20;
	int rx_wait       = 0;
	int rx_cycles     = 0;
	bit long_hold_done = 1'b0;

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Count cycles and stop a hung run
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d digests outstanding", cycles, digest_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Build the additive constants from the sine function
	function automatic void fill_sine();
		real r;
		int i;
		for (i = 0; i < 64; i++) begin
			r = $sin(real'(i + 1));
			if (r < 0.0)
				r = -r;
			sine_k[i] = 32'(longint'($floor(r * 4294967296.0)));
		end
	endfunction

	// Return the predictor to the start of a message
	function automatic void digest_restart();
		int i;
		chain[0] = 32'h67452301;
		chain[1] = 32'hefcdab89;
		chain[2] = 32'h98badcfe;
		chain[3] = 32'h10325476;
		for (i = 0; i < 64; i++)
			block_bytes[i] = 8'h00;
		byte_total = '0;
	endfunction

	// Run the 64 steps over the current block and fold into the chaining words
	function automatic void digest_compress();
		logic [31:0] a, b, c, d, f, t, nb, w;
		int k, g, grp, s;
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		for (k = 0; k < 64; k++) begin
			grp = k / 16;
			case (grp)
				0: begin
					f = (b & c) | (~b & d);
					g = k;
				end
				1: begin
					f = (b & d) | (c & ~d);
					g = (5 * k + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * k + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * k) % 16;
				end
			endcase
			w = {block_bytes[4*g+3], block_bytes[4*g+2], block_bytes[4*g+1], block_bytes[4*g]};
			t = a + f + sine_k[k] + w;
			s = ROT_AMT[4*grp + k%4];
			nb = b + ((t << s) | (t >> (32 - s)));
			a = d;
			d = c;
			c = b;
			b = nb;
		end
		chain[0] = chain[0] + a;
		chain[1] = chain[1] + b;
		chain[2] = chain[2] + c;
		chain[3] = chain[3] + d;
	endfunction

	// Take one byte; on the last one pad, finish and return the folded digest
	function automatic bit digest_take_byte(input logic [7:0] data, input logic last,
			output logic [63:0] hash);
		logic [63:0] bit_len;
		logic [31:0] w0, w1;
		int pos, i;
		hash = '0;
		pos = int'(byte_total[5:0]);
		block_bytes[pos] = data;
		byte_total = byte_total + 61'd1;
		if (pos == 63)
			digest_compress();
		if (!last)
			return 1'b0;

		// Append the marker, spill into a second block if the length no longer fits
		pos = int'(byte_total[5:0]);
		bit_len = {byte_total, 3'b000};
		block_bytes[pos] = 8'h80;
		pos++;
		if (pos > 56) begin
			while (pos < 64) begin
				block_bytes[pos] = 8'h00;
				pos++;
			end
			digest_compress();
			pos = 0;
		end
		while (pos < 56) begin
			block_bytes[pos] = 8'h00;
			pos++;
		end
		for (i = 0; i < 8; i++)
			block_bytes[56+i] = bit_len[8*i +: 8];
		digest_compress();

		// Fold the 16-byte digest to 8 bytes, first digest byte on top
		w0 = chain[0] ^ chain[2];
		w1 = chain[1] ^ chain[3];
		hash = {w0[7:0], w0[15:8], w0[23:16], w0[31:24],
			w1[7:0], w1[15:8], w1[23:16], w1[31:24]};
		digest_restart();
		return 1'b1;
	endfunction

	// Gap length: mostly short, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(12, 60);
	endfunction

	// Message length: short ones, ones near the block and padding boundaries, a few long
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return $urandom_range(1, 20);
		if (r < 8)
			return 64 * $urandom_range(0, 1) + $urandom_range(53, 66);
		return $urandom_range(1, 200);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("[%0t] ERROR %s: got %h want %h", $realtime, what, got, want);
		errors++;
	endtask

	// Score one output transfer against the oldest expected digest
	task automatic check_digest(input logic [63:0] got);
		logic [63:0] want;
		if (digest_q.size() == 0) begin
			report_mismatch("digest with none expected", got, 'x);
		end else begin
			want = digest_q.pop_front();
			if (got !== want)
				report_mismatch("folded digest", got, want);
		end
		results_seen++;
	endtask

	// Offer one byte, hold until the transfer, then maybe idle
	task automatic send_byte(input logic [7:0] data, input logic last, input logic known,
			input logic [63:0] hash);
		logic [63:0] pred;
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (digest_take_byte(data, last, pred))
			digest_q.push_back(known ? hash : pred);
		bytes_sent++;
		if (last)
			msgs_sent++;
		// Switch between bursts with no gaps and gappy stretches
		if (bytes_sent % 100 == 0)
			tx_idle_pct = $urandom_range(0, 1) ? 0 : 35;
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			gap = idle_len();
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering until every expected digest has come out
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (digest_q.size() != 0)
			@(posedge clk);
	endtask

	// Output side: score transfers, stall at random, one long hold-off
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				check_digest(m_tdata);
			rx_cycles++;
			if (rx_cycles % 256 == 0)
				rx_idle_pct = $urandom_range(0, 1) ? 0 : 25;
			if (!long_hold_done && results_seen == 8) begin
				long_hold_done = 1'b1;
				rx_wait = LONG_HOLD;
			end
			if (rx_wait > 0) begin
				rx_wait--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 99) < rx_idle_pct) begin
				rx_wait = idle_len();
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Input side: reset, directed table, then random messages
	initial begin
		int n, len, i;
		logic [7:0] data;
		bit printable;
		bit mid_drain;
		fill_sine();
		digest_restart();
		mid_drain = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_N; i++)
			send_byte(DIR_ROWS[i].data, DIR_ROWS[i].last, DIR_ROWS[i].known, DIR_ROWS[i].hash);
		drain_results();

		// Random messages, text-like or arbitrary bytes
		n = 0;
		while (n < RANDOM_BYTES) begin
			if (!mid_drain && n >= RANDOM_BYTES / 2) begin
				drain_results();
				mid_drain = 1'b1;
			end
			len = pick_len();
			if (len > int'(RANDOM_BYTES) - n)
				len = int'(RANDOM_BYTES) - n;
			printable = ($urandom_range(0, 3) == 0);
			for (i = 0; i < len; i++) begin
				data = printable ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
				send_byte(data, i == len - 1, 1'b0, '0);
			end
			n += len;
		end

		drain_results();
		repeat (SETTLE) @(posedge clk);

		$display("run covered %0d bytes in %0d messages, %0d folded digests scored",
			bytes_sent, msgs_sent, results_seen);
		$display("including block and padding-spill lengths, output stalls and a long hold-off;"
			, " %0d mismatches", errors);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/md5xf_pkg.sv
sv/md5xf_dp.sv
sv/md5xf_ctrl.sv
sv/md5_xor_folded_digest_top.sv
dv/tb_md5_xor_folded_digest_top.sv
